// ----- design/imadec_pkg.sv -----
// shared types, tables and constants of the ima adpcm nibble decoder
`timescale 1ns / 1ps

package imadec_pkg;

   // configuration register indexes
   localparam int unsigned REG_STEREO_MODE = 0;

   // highest legal step index
   localparam logic [6:0] IDX_MAX = 7'd88;

   // queue sizes between front and back, and at the result side
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int unsigned QCNT_W      = QPTR_W + 1;

   // step index adjustment, chosen by the low three bits of a nibble
   localparam logic signed [4:0] IDX_ADJ [0:7] = '{
      -5'sd1, -5'sd1, -5'sd1, -5'sd1, 5'sd2, 5'sd4, 5'sd6, 5'sd8
   };

   // step size table, one entry per step index
   localparam logic [14:0] STEP_TAB [0:88] = '{
      15'd7,     15'd8,     15'd9,     15'd10,    15'd11,
      15'd12,    15'd13,    15'd14,    15'd16,    15'd17,
      15'd19,    15'd21,    15'd23,    15'd25,    15'd28,
      15'd31,    15'd34,    15'd37,    15'd41,    15'd45,
      15'd50,    15'd55,    15'd60,    15'd66,    15'd73,
      15'd80,    15'd88,    15'd97,    15'd107,   15'd118,
      15'd130,   15'd143,   15'd157,   15'd173,   15'd190,
      15'd209,   15'd230,   15'd253,   15'd279,   15'd307,
      15'd337,   15'd371,   15'd408,   15'd449,   15'd494,
      15'd544,   15'd598,   15'd658,   15'd724,   15'd796,
      15'd876,   15'd963,   15'd1060,  15'd1166,  15'd1282,
      15'd1411,  15'd1552,  15'd1707,  15'd1878,  15'd2066,
      15'd2272,  15'd2499,  15'd2749,  15'd3024,  15'd3327,
      15'd3660,  15'd4026,  15'd4428,  15'd4871,  15'd5358,
      15'd5894,  15'd6484,  15'd7132,  15'd7845,  15'd8630,
      15'd9493,  15'd10442, 15'd11487, 15'd12635, 15'd13899,
      15'd15289, 15'd16818, 15'd18500, 15'd20350, 15'd22385,
      15'd24623, 15'd27086, 15'd29794, 15'd32767
   };

   // one nibble operation from the front to the back
   typedef struct packed {
      logic       restart;
      logic [3:0] nibble;
      logic       chan;
      logic       last_of_pair;
      logic       end_of_block;
   } op_type;

   // one decoded result transaction
   typedef struct packed {
      logic signed [15:0] sample;
      logic               channel;
      logic               last_of_pair;
      logic               end_of_block;
   } rsp_type;

endpackage

// ----- design/imadec_front.sv -----
// front end: takes request transactions and splits them into nibble operations
`timescale 1ns / 1ps

module imadec_front
   import imadec_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       stereo_mode,
   input  logic       push,
   output logic       full,
   input  logic       req_action,
   input  logic [7:0] req_code_byte,
   input  logic       req_last_byte,
   output logic       op_valid,
   output op_type     op_out,
   input  logic       op_take
);

   // holding stage for the accepted transaction
   logic              hold_valid_ff, hold_valid_in;
   logic              hold_action_ff, hold_action_in;
   logic [7:0]        hold_byte_ff, hold_byte_in;
   logic              hold_last_ff, hold_last_in;
   logic              phase_ff, phase_in;

   // operation queue towards the back end
   op_type            q_mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] q_wr_ff, q_wr_in;
   logic [QPTR_W-1:0] q_rd_ff, q_rd_in;
   logic [QCNT_W-1:0] q_cnt_ff, q_cnt_in;

   logic   emit;
   logic   finishing;
   logic   accept;
   logic   q_pop;
   op_type new_op;

   // issue one operation per cycle while the queue has room
   always_comb begin
      emit      = hold_valid_ff && (q_cnt_ff < QCNT_W'(QUEUE_DEPTH));
      finishing = emit && (hold_action_ff || phase_ff);
      full      = hold_valid_ff && !finishing;
      accept    = push && !full;
      q_pop     = op_take && op_valid;
   end

   // classify: restart, low nibble or high nibble
   always_comb begin
      new_op.restart      = hold_action_ff;
      new_op.nibble       = phase_ff ? hold_byte_ff[7:4] : hold_byte_ff[3:0];
      new_op.chan         = phase_ff && stereo_mode;
      new_op.last_of_pair = phase_ff;
      new_op.end_of_block = phase_ff && hold_last_ff;
   end

   // next state of the holding stage
   always_comb begin
      hold_valid_in  = hold_valid_ff;
      hold_action_in = hold_action_ff;
      hold_byte_in   = hold_byte_ff;
      hold_last_in   = hold_last_ff;
      phase_in       = phase_ff;
      if (finishing) begin
         hold_valid_in = 1'b0;
         phase_in      = 1'b0;
      end else if (emit) begin
         phase_in = 1'b1;
      end
      if (accept) begin
         hold_valid_in  = 1'b1;
         hold_action_in = req_action;
         hold_byte_in   = req_code_byte;
         hold_last_in   = req_last_byte;
         phase_in       = 1'b0;
      end
   end

   // queue pointers
   always_comb begin
      q_wr_in  = emit ? q_wr_ff + 1'b1 : q_wr_ff;
      q_rd_in  = q_pop ? q_rd_ff + 1'b1 : q_rd_ff;
      q_cnt_in = q_cnt_ff;
      if (emit && !q_pop) begin
         q_cnt_in = q_cnt_ff + 1'b1;
      end else if (!emit && q_pop) begin
         q_cnt_in = q_cnt_ff - 1'b1;
      end
   end

   assign op_valid = (q_cnt_ff != '0);
   assign op_out   = q_mem_ff[q_rd_ff];

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
         phase_ff      <= 1'b0;
         q_wr_ff       <= '0;
         q_rd_ff       <= '0;
         q_cnt_ff      <= '0;
      end else begin
         hold_valid_ff <= hold_valid_in;
         phase_ff      <= phase_in;
         q_wr_ff       <= q_wr_in;
         q_rd_ff       <= q_rd_in;
         q_cnt_ff      <= q_cnt_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      hold_action_ff <= hold_action_in;
      hold_byte_ff   <= hold_byte_in;
      hold_last_ff   <= hold_last_in;
      if (emit) begin
         q_mem_ff[q_wr_ff] <= new_op;
      end
   end

   // a decode transaction issues its low nibble before it lets go
   a_low_then_high: assert property (@(posedge clock) disable iff (reset)
      (emit && !hold_action_ff && !phase_ff) |=> (hold_valid_ff && phase_ff))
      else $error("front released a byte after its low nibble");

   // queue fill never passes its depth
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      q_cnt_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("operation queue overfilled");

endmodule

// ----- design/imadec_back.sv -----
// back end: decodes one nibble per cycle into a result queue that has room
`timescale 1ns / 1ps

module imadec_back
   import imadec_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               op_valid,
   input  op_type             op_in,
   output logic               op_take,
   output logic               empty,
   input  logic               pop,
   output logic signed [15:0] rsp_sample,
   output logic               rsp_channel,
   output logic               rsp_last_of_pair,
   output logic               rsp_end_of_block
);

   // per channel decoder state
   logic signed [15:0] pred_ff [2];
   logic [6:0]         idx_ff [2];
   logic [14:0]        step_ff [2];

   // result queue
   rsp_type            r_mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  r_wr_ff, r_wr_in;
   logic [QPTR_W-1:0]  r_rd_ff, r_rd_in;
   logic [QCNT_W-1:0]  r_cnt_ff, r_cnt_in;

   logic               do_decode;
   logic               do_restart;
   logic               r_pop;
   logic signed [15:0] cur_pred;
   logic [6:0]         cur_idx;
   logic [14:0]        cur_step;
   logic signed [4:0]  adj;
   logic [7:0]         idx_sum;
   logic [6:0]         new_idx;
   logic [15:0]        delta;
   logic signed [17:0] pred_sum;
   logic signed [15:0] new_pred;
   rsp_type            new_rsp;

   // take an operation when the result queue has room
   always_comb begin
      op_take    = op_valid && (r_cnt_ff < QCNT_W'(QUEUE_DEPTH));
      do_restart = op_take && op_in.restart;
      do_decode  = op_take && !op_in.restart;
      r_pop      = pop && !empty;
   end

   // step index update and clamp
   always_comb begin
      cur_pred = pred_ff[op_in.chan];
      cur_idx  = idx_ff[op_in.chan];
      cur_step = step_ff[op_in.chan];
      adj      = IDX_ADJ[op_in.nibble[2:0]];
      idx_sum  = {1'b0, cur_idx} + {{3{adj[4]}}, adj};
      if (idx_sum[7]) begin
         new_idx = '0;
      end else if (idx_sum[6:0] > IDX_MAX) begin
         new_idx = IDX_MAX;
      end else begin
         new_idx = idx_sum[6:0];
      end
   end

   // delta from shifts of the old step, then saturating predictor add
   always_comb begin
      delta = 16'(cur_step >> 3);
      if (op_in.nibble[0]) delta = delta + 16'(cur_step >> 2);
      if (op_in.nibble[1]) delta = delta + 16'(cur_step >> 1);
      if (op_in.nibble[2]) delta = delta + 16'(cur_step);
      pred_sum = {{2{cur_pred[15]}}, cur_pred}
               + (op_in.nibble[3] ? -$signed({2'b00, delta}) : $signed({2'b00, delta}));
      if (!pred_sum[17] && (pred_sum[16:15] != 2'b00)) begin
         new_pred = 16'sh7FFF;
      end else if (pred_sum[17] && (pred_sum[16:15] != 2'b11)) begin
         new_pred = -16'sh8000;
      end else begin
         new_pred = pred_sum[15:0];
      end
   end

   always_comb begin
      new_rsp.sample       = new_pred;
      new_rsp.channel      = op_in.chan;
      new_rsp.last_of_pair = op_in.last_of_pair;
      new_rsp.end_of_block = op_in.end_of_block;
   end

   // decoder state: restart clears both channels
   always_ff @(posedge clock) begin
      if (reset || do_restart) begin
         for (int c = 0; c < 2; c++) begin
            pred_ff[c] <= '0;
            idx_ff[c]  <= '0;
            step_ff[c] <= STEP_TAB[0];
         end
      end else if (do_decode) begin
         pred_ff[op_in.chan] <= new_pred;
         idx_ff[op_in.chan]  <= new_idx;
         step_ff[op_in.chan] <= STEP_TAB[new_idx];
      end
   end

   // result queue pointers
   always_comb begin
      r_wr_in  = do_decode ? r_wr_ff + 1'b1 : r_wr_ff;
      r_rd_in  = r_pop ? r_rd_ff + 1'b1 : r_rd_ff;
      r_cnt_in = r_cnt_ff;
      if (do_decode && !r_pop) begin
         r_cnt_in = r_cnt_ff + 1'b1;
      end else if (!do_decode && r_pop) begin
         r_cnt_in = r_cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         r_wr_ff  <= '0;
         r_rd_ff  <= '0;
         r_cnt_ff <= '0;
      end else begin
         r_wr_ff  <= r_wr_in;
         r_rd_ff  <= r_rd_in;
         r_cnt_ff <= r_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_decode) begin
         r_mem_ff[r_wr_ff] <= new_rsp;
      end
   end

   // result ports show the oldest waiting transaction
   assign empty            = (r_cnt_ff == '0);
   assign rsp_sample       = r_mem_ff[r_rd_ff].sample;
   assign rsp_channel      = r_mem_ff[r_rd_ff].channel;
   assign rsp_last_of_pair = r_mem_ff[r_rd_ff].last_of_pair;
   assign rsp_end_of_block = r_mem_ff[r_rd_ff].end_of_block;

   // stored step always matches the table at the stored index
   a_step_matches_idx: assert property (@(posedge clock) disable iff (reset)
      (step_ff[0] == STEP_TAB[idx_ff[0]]) && (step_ff[1] == STEP_TAB[idx_ff[1]]))
      else $error("step size out of step with step index");

   // restart leaves both channels at their cleared values and queues nothing
   a_restart_clears: assert property (@(posedge clock) disable iff (reset)
      do_restart |=> (pred_ff[0] == '0) && (pred_ff[1] == '0) && (idx_ff[0] == '0)
                     && (idx_ff[1] == '0) && (r_cnt_ff <= $past(r_cnt_ff)))
      else $error("restart did not clear decoder state");

endmodule

// ----- design/ima_adpcm_nibble_decoder.sv -----
// top level of the ima adpcm nibble decoder: register port, front and back
//
//   channel  | handshake            | payload
//   ---------+----------------------+---------------------------------------------
//   request  | push / full          | req_action, req_code_byte, req_last_byte
//   result   | pop / empty          | rsp_sample, rsp_channel, rsp_last_of_pair,
//            |                      | rsp_end_of_block
//   csr      | psel/penable/pready  | paddr, pwdata, prdata (stereo_mode at 0x0)
//
// a decode byte splits into a low then a high nibble operation; the front issues
// one per cycle, while the queue has room, to the back's single decode unit
// a result reaches the result ports through the holding stage and both queues
// synchronous active high reset clears both channel states and stereo_mode
// a stalled result side fills the result queue, then the operation queue,
// then raises full; no transaction is lost
`timescale 1ns / 1ps

module ima_adpcm_nibble_decoder
   import imadec_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   // request channel
   input  logic               push,
   output logic               full,
   input  logic               req_action,
   input  logic [7:0]         req_code_byte,
   input  logic               req_last_byte,
   // result channel
   output logic               empty,
   input  logic               pop,
   output logic signed [15:0] rsp_sample,
   output logic               rsp_channel,
   output logic               rsp_last_of_pair,
   output logic               rsp_end_of_block,
   // configuration port
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [2:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);

   logic   stereo_ff;
   logic   csr_hit;
   logic   op_valid;
   logic   op_take;
   op_type op_bus;

   // register decode, word addressed
   assign pready  = 1'b1;
   assign csr_hit = (paddr[2] == 1'(REG_STEREO_MODE));

   always_ff @(posedge clock) begin
      if (reset) begin
         stereo_ff <= 1'b0;
      end else if (psel && penable && pwrite && pready && csr_hit) begin
         stereo_ff <= pwdata[0];
      end
   end

   assign prdata = csr_hit ? {31'd0, stereo_ff} : 32'd0;

   // front: accept and split transactions
   imadec_front u_front (
      .clock         (clock),
      .reset         (reset),
      .stereo_mode   (stereo_ff),
      .push          (push),
      .full          (full),
      .req_action    (req_action),
      .req_code_byte (req_code_byte),
      .req_last_byte (req_last_byte),
      .op_valid      (op_valid),
      .op_out        (op_bus),
      .op_take       (op_take)
   );

   // back: decode nibbles and queue results
   imadec_back u_back (
      .clock            (clock),
      .reset            (reset),
      .op_valid         (op_valid),
      .op_in            (op_bus),
      .op_take          (op_take),
      .empty            (empty),
      .pop              (pop),
      .rsp_sample       (rsp_sample),
      .rsp_channel      (rsp_channel),
      .rsp_last_of_pair (rsp_last_of_pair),
      .rsp_end_of_block (rsp_end_of_block)
   );

endmodule
